>>> hdl/ultrasonic_echo_ranger_defines.svh
// Assertion macros used by the checker file.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define UER_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define UER_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_ACTIVE = 2'd1,
		ST_FIRST  = 2'd2,
		ST_UNRESP = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_OK        = 2'd0,
		CMD_REDUNDANT = 2'd1,
		CMD_NONE      = 2'd2
	} cmd_res_t;

	typedef enum logic [5:0] {
		PH_SEND = 6'b000001,
		PH_HIGH = 6'b000010,
		PH_RISE = 6'b000100,
		PH_FALL = 6'b001000,
		PH_DONE = 6'b010000,
		PH_TOUT = 6'b100000
	} phase_t;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam logic [1:0] CFG_TRIGGER_TICKS = 2'd0;
	localparam logic [1:0] CFG_RISE_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_FALL_TIMEOUT  = 2'd2;
	localparam logic [1:0] CFG_CM_PER_TICK   = 2'd3;

	localparam logic [15:0] RST_TRIGGER_TICKS = 16'd10;
	localparam logic [15:0] RST_RISE_TIMEOUT  = 16'd30000;
	localparam logic [15:0] RST_FALL_TIMEOUT  = 16'd30000;
	localparam logic [15:0] RST_CM_PER_TICK   = 16'd1114;

endpackage

>>> hdl/uer_if.sv
`timescale 1ns / 1ps

interface uer_tick_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       echo_level;

	modport source (output valid, output operation, output echo_level, input ready);
	modport sink (input valid, input operation, input echo_level, output ready);
endinterface

interface uer_result_if;
	logic        valid;
	logic        ready;
	logic        trigger_level;
	logic [1:0]  status;
	logic [1:0]  command_result;
	logic [15:0] distance_cm;
	logic        new_measurement;

	modport source (output valid, output trigger_level, output status, output command_result,
		output distance_cm, output new_measurement, input ready);
	modport sink (input valid, input trigger_level, input status, input command_result,
		input distance_cm, input new_measurement, output ready);
endinterface

interface uer_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// A result passes the input register, the state update and the distance multiply
// into the output register. Throughput: one tick per cycle unless result.ready
// stalls the output; the sensor state machine advances once per tick.
// Reset (arst_n low) clears the pipeline, sets status idle in the send-trigger phase
// and loads the register defaults 10, 30000, 30000 and 1114.
module ultrasonic_echo_ranger #(
	parameter int COUNT_WIDTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	uer_cfg_if.sink      cfg,
	uer_tick_if.sink     tick,
	uer_result_if.source result
);
	import uer_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [15:0] trig_ticks_q;
	logic [15:0] rise_tout_q;
	logic [15:0] fall_tout_q;
	logic [15:0] cm_per_tick_q;

	status_t                status_q;
	phase_t                 phase_q;
	logic [COUNT_WIDTH-1:0] timer_q;
	logic [COUNT_WIDTH-1:0] width_q;
	logic                   prev_echo_q;
	logic                   trig_q;

	logic       v_s1;
	logic [1:0] op_s1;
	logic       echo_s1;

	logic                   v_s2;
	logic                   trig_s2;
	status_t                status_s2;
	cmd_res_t               cmd_s2;
	logic                   fresh_s2;
	logic [COUNT_WIDTH-1:0] width_s2;

	logic     v_s3;
	logic     trig_s3;
	status_t  status_s3;
	cmd_res_t cmd_s3;
	logic     fresh_s3;
	logic [15:0] dist_s3;

	logic en1, en2, en3, step;

	status_t                n_status;
	phase_t                 n_phase;
	logic [COUNT_WIDTH-1:0] n_timer;
	logic [COUNT_WIDTH-1:0] n_width;
	logic                   n_trig;
	cmd_res_t               n_cmd;
	logic                   n_fresh;
	logic [15:0]            dist_calc;

	assign en3  = !v_s3 || result.ready;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign step = v_s1 && en2;

	assign tick.ready = en1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q  <= RST_TRIGGER_TICKS;
			rise_tout_q   <= RST_RISE_TIMEOUT;
			fall_tout_q   <= RST_FALL_TIMEOUT;
			cm_per_tick_q <= RST_CM_PER_TICK;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TRIGGER_TICKS: trig_ticks_q  <= cfg.data;
				CFG_RISE_TIMEOUT:  rise_tout_q   <= cfg.data;
				CFG_FALL_TIMEOUT:  fall_tout_q   <= cfg.data;
				CFG_CM_PER_TICK:   cm_per_tick_q <= cfg.data;
			endcase
		end
	end

	// Commands act first, then the phase step runs on the updated status.
	always_comb begin
		n_status = status_q;
		n_phase  = phase_q;
		n_timer  = timer_q;
		n_width  = width_q;
		n_trig   = trig_q;
		n_cmd    = CMD_NONE;
		n_fresh  = 1'b0;

		if (op_s1 == OP_START) begin
			if (status_q == ST_IDLE || status_q == ST_UNRESP) begin
				n_status = ST_FIRST;
				n_phase  = PH_SEND;
				n_timer  = '0;
				n_trig   = 1'b0;
				n_cmd    = CMD_OK;
			end else begin
				n_cmd = CMD_REDUNDANT;
			end
		end else if (op_s1 == OP_STOP) begin
			if (status_q != ST_IDLE) begin
				n_status = ST_IDLE;
				n_phase  = PH_SEND;
				n_timer  = '0;
				n_trig   = 1'b0;
				n_cmd    = CMD_OK;
			end else begin
				n_cmd = CMD_REDUNDANT;
			end
		end

		if (n_status == ST_UNRESP) begin
			n_status = ST_FIRST;
			n_phase  = PH_SEND;
			n_timer  = '0;
			n_trig   = 1'b0;
		end else if (n_status != ST_IDLE) begin
			unique case (n_phase)
				PH_SEND: begin
					n_trig  = 1'b1;
					n_timer = '0;
					n_phase = PH_HIGH;
				end
				PH_HIGH: begin
					if (n_timer != CNT_MAX) begin
						n_timer = n_timer + 1'b1;
					end
					if (CMP_W'(n_timer) >= CMP_W'(trig_ticks_q) || n_timer == CNT_MAX) begin
						n_trig  = 1'b0;
						n_timer = '0;
						n_phase = PH_RISE;
					end
				end
				PH_RISE: begin
					if (!prev_echo_q && echo_s1) begin
						n_timer = COUNT_WIDTH'(1);
						n_phase = PH_FALL;
					end else begin
						if (n_timer != CNT_MAX) begin
							n_timer = n_timer + 1'b1;
						end
						if (CMP_W'(n_timer) >= CMP_W'(rise_tout_q) || n_timer == CNT_MAX) begin
							n_status = ST_UNRESP;
							n_phase  = PH_TOUT;
						end
					end
				end
				PH_FALL: begin
					if (!echo_s1) begin
						n_width  = n_timer;
						n_fresh  = 1'b1;
						n_status = ST_ACTIVE;
						n_phase  = PH_DONE;
					end else begin
						if (n_timer != CNT_MAX) begin
							n_timer = n_timer + 1'b1;
						end
						if (CMP_W'(n_timer) >= CMP_W'(fall_tout_q) || n_timer == CNT_MAX) begin
							n_status = ST_UNRESP;
							n_phase  = PH_TOUT;
						end
					end
				end
				default: begin
					n_phase = PH_SEND;
					n_timer = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ST_IDLE;
			phase_q     <= PH_SEND;
			timer_q     <= '0;
			width_q     <= '0;
			prev_echo_q <= 1'b0;
			trig_q      <= 1'b0;
		end else if (step) begin
			status_q    <= n_status;
			phase_q     <= n_phase;
			timer_q     <= n_timer;
			width_q     <= n_width;
			prev_echo_q <= echo_s1;
			trig_q      <= n_trig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= tick.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= tick.operation;
			echo_s1 <= tick.echo_level;
		end
		if (step) begin
			trig_s2   <= n_trig;
			status_s2 <= n_status;
			cmd_s2    <= n_cmd;
			fresh_s2  <= n_fresh;
			width_s2  <= n_width;
		end
		if (en3 && v_s2) begin
			trig_s3   <= trig_s2;
			status_s3 <= status_s2;
			cmd_s3    <= cmd_s2;
			fresh_s3  <= fresh_s2;
			dist_s3   <= dist_calc;
		end
	end

	uer_scale #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_scale (
		.echo_width(width_s2),
		.cm_per_tick_q16(cm_per_tick_q),
		.distance_cm(dist_calc)
	);

	assign result.valid           = v_s3;
	assign result.trigger_level   = trig_s3;
	assign result.status          = status_s3;
	assign result.command_result  = cmd_s3;
	assign result.distance_cm     = dist_s3;
	assign result.new_measurement = fresh_s3;
endmodule

>>> hdl/uer_scale.sv
`timescale 1ns / 1ps

module uer_scale #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic [COUNT_WIDTH-1:0] echo_width,
	input  logic [15:0]            cm_per_tick_q16,
	output logic [15:0]            distance_cm
);
	localparam int PROD_W = COUNT_WIDTH + 16;
	localparam int EXT_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	logic [PROD_W-1:0]      product;
	logic [EXT_W-1:0]       dist_ext;

	always_comb begin
		product  = PROD_W'(echo_width) * PROD_W'(cm_per_tick_q16);
		dist_ext = EXT_W'(product[PROD_W-1:16]);
		if (dist_ext > EXT_W'(16'hFFFF)) begin
			distance_cm = 16'hFFFF;
		end else begin
			distance_cm = dist_ext[15:0];
		end
	end
endmodule

>>> hdl/uer_checker.sv
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_trigger,
	input logic [1:0]  res_status,
	input logic [1:0]  res_cmd,
	input logic [15:0] res_dist,
	input logic        res_fresh
);
	import uer_pkg::*;

	`UER_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res_trigger) && $stable(res_status) && $stable(res_cmd) && $stable(res_dist) && $stable(res_fresh), "Stalled result changed")

	`UER_ASSERT_IMPL(a_fresh_active, res_valid && res_fresh, res_status == ST_ACTIVE, "Capture without active status")

	`UER_ASSERT_IMPL(a_fresh_trig_low, res_valid && res_fresh, !res_trigger, "Trigger high during a capture")

	`UER_ASSERT_IMPL(a_trig_running, res_valid && res_trigger, res_status == ST_FIRST || res_status == ST_ACTIVE, "Trigger high while not running")
endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_trigger(result.trigger_level),
	.res_status(result.status),
	.res_cmd(result.command_result),
	.res_dist(result.distance_cm),
	.res_fresh(result.new_measurement)
);
